// ===== hw/rtl/bxf_pkg.sv =====
// Package for the 5x5 box filter: widths, constants, register indexes and
// the record carried from the front end to the back end.
// No dependencies.
package bxf_pkg;

    // Field and register widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 12;
    localparam int HEIGHT_W  = 12;
    localparam int CFG_IDX_W = 1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Reset values and default sizes
    localparam int RESET_WIDTH   = 640;
    localparam int RESET_HEIGHT  = 480;
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int QUEUE_DEPTH   = 4;

    // Window arithmetic: five pixels per column, 25 per window
    localparam int COLSUM_W = 11;
    localparam int WSUM_W   = 13;

    // floor(s / 25) == (s * 10486) >> 18 for every s below 43690
    localparam int                   RECIP_W     = 14;
    localparam logic [RECIP_W-1:0]   RECIP_25    = 14'd10486;
    localparam int                   RECIP_SHIFT = 18;
    localparam int                   PROD_W      = WSUM_W + RECIP_W;

    // One column of the window, classified by the front end
    typedef struct packed {
        logic [COLSUM_W-1:0] col_sum;  // sum of the five pixels of the new column
        logic [PIX_W-1:0]    mid;      // pixel on the middle row of the new column
        logic                emit;     // this transaction produces a result
        logic                interior; // result is the mean, else the centre pixel
        logic                last;     // result closes the frame
    } qent_t;

    // Front end status seen by the top level
    typedef struct packed {
        logic clearing;  // line store clearing pass after reset
        logic busy;      // output position being recomputed after a register write
    } front_stat_t;

endpackage

// ===== hw/rtl/bxf_pixin_if.sv =====
// Input pixel channel: valid/ready handshake with pixel and drain flag.
// Depends on bxf_pkg.
interface bxf_pixin_if;
    logic                      valid;
    logic                      ready;
    logic [bxf_pkg::PIX_W-1:0] pixel_in;
    logic                      drain;

    modport source (output valid, output pixel_in, output drain, input ready);
    modport sink   (input valid, input pixel_in, input drain, output ready);
endinterface

// ===== hw/rtl/bxf_pixout_if.sv =====
// Output pixel channel: valid/ready handshake with filtered pixel and frame end.
// Depends on bxf_pkg.
interface bxf_pixout_if;
    logic                      valid;
    logic                      ready;
    logic [bxf_pkg::PIX_W-1:0] pixel_out;
    logic                      frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ===== hw/rtl/box_filter_5x5_mean_core.sv =====
// Top level of the 5x5 box (mean) filter: configuration registers, front end,
// queue and back end. Depends on bxf_pkg, bxf_pixin_if, bxf_pixout_if,
// bxf_front, bxf_queue and bxf_back.
//
//  channel   | direction | transaction payload      | handshake
//  ----------+-----------+--------------------------+---------------------------
//  pix_in    | in        | pixel_in[7:0], drain     | valid && ready
//  pix_out   | out       | pixel_out[7:0], frame_last | valid && ready
//  cfg       | in        | cfg_index, cfg_data[11:0] | cfg_we, no wait
//
// One pixel per clock sustained while pix_in.ready stays high; with the queue empty and
// pix_out free, a result passes column update into the queue, window total, multiply
// and the output register before it shows valid on pix_out.
// After reset the line store is cleared, one column per cycle, with pix_in.ready low.
// Each register write holds pix_in.ready low, in the write cycle itself and while
// the divider recomputes the output position.
// A four-entry queue sits between front and back; ready also drops once the
// queue and the column stage together hold four transactions.
module box_filter_5x5_mean_core #(
    parameter int MAX_WIDTH = bxf_pkg::MAX_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    bxf_pixin_if.sink                      pix_in,
    bxf_pixout_if.source                   pix_out,
    input  logic                           cfg_we,
    input  logic [bxf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bxf_pkg::CFG_W-1:0]      cfg_data
);

    localparam int WW    = $clog2(MAX_WIDTH+1);
    localparam int HW    = bxf_pkg::HEIGHT_W;
    localparam int QD    = bxf_pkg::QUEUE_DEPTH;
    localparam int CNTW  = $clog2(QD+1);
    localparam int W_RST = (bxf_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                              : bxf_pkg::RESET_WIDTH;

    logic [WW-1:0]         width_reg;
    logic [HW-1:0]         height_reg;
    logic [WW-1:0]         width_next;
    logic [HW-1:0]         height_next;

    logic                  q_push;
    logic                  q_pop;
    logic                  q_empty;
    logic [CNTW-1:0]       q_count;
    bxf_pkg::qent_t        q_in;
    bxf_pkg::qent_t        q_out;
    bxf_pkg::front_stat_t  stat;

    // Register writes store the width and height as the filter uses them
    always_comb
    begin
        width_next  = (cfg_data == '0) ? WW'(1)
                    : ((int'(cfg_data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_data));
        height_next = (cfg_data == '0) ? HW'(1) : HW'(cfg_data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(W_RST);
            height_reg <= HW'(bxf_pkg::RESET_HEIGHT);
        end
        else if (cfg_we)
        begin
            if (cfg_index == bxf_pkg::CFG_IMAGE_WIDTH)
            begin
                width_reg <= width_next;
            end
            if (cfg_index == bxf_pkg::CFG_IMAGE_HEIGHT)
            begin
                height_reg <= height_next;
            end
        end
    end

    bxf_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .QDEPTH    (QD)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .width    (width_reg),
        .height   (height_reg),
        .cfg_we   (cfg_we),
        .in_valid (pix_in.valid),
        .in_ready (pix_in.ready),
        .in_pixel (pix_in.pixel_in),
        .in_drain (pix_in.drain),
        .q_count  (q_count),
        .q_push   (q_push),
        .q_data   (q_in),
        .stat     (stat)
    );

    bxf_queue #(
        .DEPTH (QD)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty),
        .count     (q_count)
    );

    bxf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .out_pixel (pix_out.pixel_out),
        .out_last  (pix_out.frame_last)
    );

`ifndef SYNTHESIS
    // The front end never pushes into a full queue
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |-> (int'(q_count) < QD))
        else $error("queue overflow");

    // The back end never pops an empty queue
    a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue underflow");

    // No pixel is taken while the line store clears or the position is recomputed
    a_no_accept_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.clearing || stat.busy) |-> !pix_in.ready)
        else $error("pixel accepted during clearing or recompute");

    // A register write blocks the next transaction while the divider starts
    a_write_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !pix_in.ready)
        else $error("pixel accepted right after a register write");
`endif

endmodule

// ===== hw/rtl/bxf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bxf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and read-before-write on the same edge
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bxf_queue.sv =====
// Short FIFO between the front end and the back end of the box filter.
// Depends on bxf_pkg (entry type).
module bxf_queue #(
    parameter int DEPTH = bxf_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  bxf_pkg::qent_t             push_data,
    input  logic                       pop,
    output bxf_pkg::qent_t             pop_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH+1);

    bxf_pkg::qent_t  slot_reg [DEPTH];
    logic [PW-1:0]   head_reg;
    logic [PW-1:0]   tail_reg;
    logic [CNTW-1:0] count_reg;
    logic [PW-1:0]   head_next;
    logic [PW-1:0]   tail_next;
    logic [CNTW-1:0] count_next;

    // Pointer and count updates
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == PW'(DEPTH-1)) ? '0 : tail_reg + PW'(1);
        end
        if (pop)
        begin
            head_next = (head_reg == PW'(DEPTH-1)) ? '0 : head_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[head_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

endmodule

// ===== hw/rtl/bxf_front.sv =====
// Front end of the box filter: input handshake, frame position tracking,
// output classification, line store access and the position recompute divider.
// Depends on bxf_pkg and bxf_ram.
module bxf_front #(
    parameter int MAX_WIDTH = bxf_pkg::MAX_WIDTH_DEF,
    parameter int QDEPTH    = bxf_pkg::QUEUE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]     width,
    input  logic [bxf_pkg::HEIGHT_W-1:0]       height,
    input  logic                               cfg_we,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [bxf_pkg::PIX_W-1:0]          in_pixel,
    input  logic                               in_drain,
    input  logic [$clog2(QDEPTH+1)-1:0]        q_count,
    output logic                               q_push,
    output bxf_pkg::qent_t                     q_data,
    output bxf_pkg::front_stat_t               stat
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH+1);
    localparam int CW   = WW + bxf_pkg::HEIGHT_W;
    localparam int DCW  = $clog2(CW+1);
    localparam int PW   = bxf_pkg::PIX_W;
    localparam int LSW  = 4 * PW;
    localparam int CSW  = bxf_pkg::COLSUM_W;
    localparam logic [2:0] ROW_SAT = 3'd4;

    function automatic logic [2:0] row_inc(input logic [2:0] x);
        return (x == ROW_SAT) ? x : x + 3'd1;
    endfunction

    // Position state
    logic [AW-1:0]  in_col_reg;
    logic [2:0]     in_row_reg;   // saturates at four, only the first rows matter
    logic [CW-1:0]  p_reg;        // results given so far in this frame
    logic [CW-1:0]  r_reg;        // row of the next result
    logic [AW-1:0]  c_reg;        // column of the next result
    logic [CW-1:0]  total_reg;    // pixels per frame

    // Clearing pass and divider
    logic           clearing_reg;
    logic [AW-1:0]  clr_cnt_reg;
    logic [DCW-1:0] div_cnt_reg;
    logic [WW-1:0]  div_rem_reg;
    logic [CW-1:0]  div_quo_reg;

    // Second stage
    logic           b_valid_reg;
    logic [AW-1:0]  b_col_reg;
    logic [PW-1:0]  b_v_reg;
    logic           b_emit_reg;
    logic           b_int_reg;
    logic           b_last_reg;
    logic           byp_reg;
    logic [LSW-1:0] byp_data_reg;

    // First stage signals
    logic           acc;
    logic [PW-1:0]  v_a;
    logic           wrap_a;
    logic [AW-1:0]  col_a;
    logic [2:0]     row_a;
    logic           emit_a;
    logic           col_end_a;
    logic [WW-1:0]  col_inc_a;
    logic           last_a;
    logic           int_a;
    logic [WW-1:0]  c_inc;
    logic           c_wrap;

    // Divider step
    logic [WW:0]    div_shl;
    logic           div_ge;
    logic [WW-1:0]  rem_step;
    logic [CW-1:0]  quo_step;

    // Line store
    logic           ls_we;
    logic [AW-1:0]  ls_waddr;
    logic [LSW-1:0] ls_wdata;
    logic [LSW-1:0] ls_rdata;
    logic [LSW-1:0] word_b;
    logic [LSW-1:0] new_word;
    logic [CSW-1:0] col_sum;

    // Input handshake
    assign in_ready = !clearing_reg && (div_cnt_reg == '0) && !cfg_we
                      && (int'(q_count) + int'(b_valid_reg) < QDEPTH);
    assign acc = in_valid && in_ready;
    assign v_a = in_drain ? '0 : in_pixel;

    // Position of this transaction and whether it produces a result
    always_comb
    begin
        wrap_a    = (WW'(in_col_reg) >= width);
        col_a     = wrap_a ? '0 : in_col_reg;
        row_a     = wrap_a ? row_inc(in_row_reg) : in_row_reg;
        emit_a    = (row_a >= ROW_SAT)
                    || ((row_a == 3'd3) && (width != WW'(1)))
                    || ((row_a == 3'd2) && (col_a >= AW'(2)));
        col_inc_a = WW'(col_a) + WW'(1);
        col_end_a = (col_inc_a >= width);
        last_a    = emit_a && (p_reg >= total_reg - CW'(1));
        int_a     = (r_reg >= CW'(2))
                    && ((CW+1)'(r_reg) + (CW+1)'(2) < (CW+1)'(height))
                    && (c_reg >= AW'(2))
                    && ((WW+1)'(c_reg) + (WW+1)'(2) < (WW+1)'(width));
        c_inc     = WW'(c_reg) + WW'(1);
        c_wrap    = (c_inc == width);
    end

    // Restoring divider step: output position = results so far / width
    always_comb
    begin
        div_shl  = {div_rem_reg, div_quo_reg[CW-1]};
        div_ge   = (div_shl >= {1'b0, width});
        rem_step = div_ge ? WW'(div_shl - {1'b0, width}) : WW'(div_shl);
        quo_step = {div_quo_reg[CW-2:0], div_ge};
    end

    // Position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            p_reg      <= '0;
            r_reg      <= '0;
            c_reg      <= '0;
        end
        else if (acc)
        begin
            if (last_a)
            begin
                in_col_reg <= '0;
                in_row_reg <= '0;
                p_reg      <= '0;
                r_reg      <= '0;
                c_reg      <= '0;
            end
            else
            begin
                in_col_reg <= col_end_a ? '0 : AW'(col_inc_a);
                in_row_reg <= col_end_a ? row_inc(row_a) : row_a;
                if (emit_a)
                begin
                    p_reg <= p_reg + CW'(1);
                    if (c_wrap)
                    begin
                        c_reg <= '0;
                        r_reg <= r_reg + CW'(1);
                    end
                    else
                    begin
                        c_reg <= AW'(c_inc);
                    end
                end
            end
        end
        else if (div_cnt_reg == DCW'(1))
        begin
            r_reg <= quo_step;
            c_reg <= AW'(rem_step);
        end
    end

    // Frame size, settles while the divider runs after a write
    always_ff @(posedge clk)
    begin
        total_reg <= CW'(width) * CW'(height);
    end

    // Divider sequencing, restarted by every register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cfg_we)
        begin
            div_cnt_reg <= DCW'(CW);
        end
        else if (div_cnt_reg != '0)
        begin
            div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cfg_we)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= p_reg;
        end
        else if (div_cnt_reg != '0)
        begin
            div_rem_reg <= rem_step;
            div_quo_reg <= quo_step;
        end
    end

    // Line store clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(MAX_WIDTH-1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Second stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            byp_reg     <= 1'b0;
        end
        else
        begin
            b_valid_reg <= acc;
            byp_reg     <= acc && b_valid_reg && (col_a == b_col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            b_col_reg  <= col_a;
            b_v_reg    <= v_a;
            b_emit_reg <= emit_a;
            b_int_reg  <= int_a;
            b_last_reg <= last_a;
        end
        byp_data_reg <= new_word;
    end

    // Column shift of the line store: slot k takes slot k+1, the newest takes the pixel
    always_comb
    begin
        word_b   = byp_reg ? byp_data_reg : ls_rdata;
        new_word = {b_v_reg, word_b[3*PW +: PW], word_b[2*PW +: PW], word_b[PW +: PW]};
        col_sum  = CSW'(word_b[0 +: PW]) + CSW'(word_b[PW +: PW])
                   + CSW'(word_b[2*PW +: PW]) + CSW'(word_b[3*PW +: PW])
                   + CSW'(b_v_reg);
    end

    assign ls_we    = clearing_reg || b_valid_reg;
    assign ls_waddr = clearing_reg ? clr_cnt_reg : b_col_reg;
    assign ls_wdata = clearing_reg ? '0 : new_word;

    bxf_ram #(
        .WIDTH (LSW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ls_we),
        .waddr (ls_waddr),
        .wdata (ls_wdata),
        .raddr (col_a),
        .rdata (ls_rdata)
    );

    // Hand the column to the back end
    assign q_push           = b_valid_reg;
    assign q_data.col_sum   = col_sum;
    assign q_data.mid       = word_b[2*PW +: PW];
    assign q_data.emit      = b_emit_reg;
    assign q_data.interior  = b_int_reg;
    assign q_data.last      = b_last_reg;

    assign stat.clearing = clearing_reg;
    assign stat.busy     = (div_cnt_reg != '0);

endmodule

// ===== hw/rtl/bxf_back.sv =====
// Back end of the box filter: 5x5 window of column sums, divide by 25,
// border select and the output register.
// Depends on bxf_pkg.
module bxf_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  bxf_pkg::qent_t            q_data,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [bxf_pkg::PIX_W-1:0] out_pixel,
    output logic                      out_last
);

    localparam int PW  = bxf_pkg::PIX_W;
    localparam int CSW = bxf_pkg::COLSUM_W;
    localparam int SW  = bxf_pkg::WSUM_W;
    localparam int MW  = bxf_pkg::PROD_W;

    // Window state: five column sums, running total, middle pixels of the newest columns
    logic [CSW-1:0] cs_reg [5];
    logic [SW-1:0]  wsum_reg;
    logic [PW-1:0]  mid3_reg;
    logic [PW-1:0]  mid4_reg;
    logic [SW-1:0]  wsum_next;

    // Pipeline
    logic           en;
    logic           s1_valid_reg;
    logic [SW-1:0]  s1_sum_reg;
    logic [PW-1:0]  s1_mid_reg;
    logic           s1_int_reg;
    logic           s1_last_reg;
    logic           s2_valid_reg;
    logic [MW-1:0]  s2_prod_reg;
    logic [PW-1:0]  s2_mid_reg;
    logic           s2_int_reg;
    logic           s2_last_reg;
    logic           out_valid_reg;
    logic [PW-1:0]  out_pixel_reg;
    logic           out_last_reg;

    // Whole pipeline moves unless the output register is held
    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en && !q_empty;

    assign wsum_next = wsum_reg - SW'(cs_reg[0]) + SW'(q_data.col_sum);

    // Window shift on every popped column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 5; j++)
            begin
                cs_reg[j] <= '0;
            end
            wsum_reg <= '0;
            mid3_reg <= '0;
            mid4_reg <= '0;
        end
        else if (q_pop)
        begin
            for (int j = 0; j < 4; j++)
            begin
                cs_reg[j] <= cs_reg[j+1];
            end
            cs_reg[4] <= q_data.col_sum;
            wsum_reg  <= wsum_next;
            mid3_reg  <= mid4_reg;
            mid4_reg  <= q_data.mid;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= q_pop && q_data.emit;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Payload: window total, product with the reciprocal of 25, final select
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sum_reg    <= wsum_next;
            s1_mid_reg    <= mid3_reg;
            s1_int_reg    <= q_data.interior;
            s1_last_reg   <= q_data.last;
            s2_prod_reg   <= MW'(s1_sum_reg) * MW'(bxf_pkg::RECIP_25);
            s2_mid_reg    <= s1_mid_reg;
            s2_int_reg    <= s1_int_reg;
            s2_last_reg   <= s1_last_reg;
            out_pixel_reg <= s2_int_reg ? s2_prod_reg[bxf_pkg::RECIP_SHIFT +: PW] : s2_mid_reg;
            out_last_reg  <= s2_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== verif/tb.sv =====
// Testbench for box_filter_5x5_mean_core: frames of pixels and drains go in,
// and every filtered pixel is checked against an in-bench model of the filter.
// Depends on bxf_pkg, bxf_pixin_if, bxf_pixout_if and the filter RTL.
module tb;

    localparam int MAXW        = bxf_pkg::MAX_WIDTH_DEF;
    localparam int PXW         = bxf_pkg::PIX_W;
    localparam int CFGW        = bxf_pkg::CFG_W;
    localparam int IDXW        = bxf_pkg::CFG_IDX_W;
    localparam int WIN_AREA    = 25;
    localparam int STUCK_LIMIT = 20000;
    localparam int SETTLE_CYC  = 20;
    localparam int LONG_STALL  = 300;
    localparam int RAND_ITEMS  = 900;
    localparam int EXT_ITEMS   = 40;

    typedef struct packed {
        logic [PXW-1:0] pix;
        logic           drain;
    } pix_item_t;

    typedef struct packed {
        logic [PXW-1:0] pix;
        logic           last;
    } mean_out_t;

    typedef enum logic [1:0] {FILL_NOISE, FILL_WHITE, FILL_BLACK, FILL_SPECKLE} fill_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [IDXW-1:0]  cfg_index;
    logic [CFGW-1:0]  cfg_data;

    bxf_pixin_if  pin ();
    bxf_pixout_if pout ();

    box_filter_5x5_mean_core #(.MAX_WIDTH(MAXW)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pin),
        .pix_out   (pout),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Filter model state
    logic [PXW-1:0]   line_mem [4][MAXW];
    logic [PXW-1:0]   win [5][5];
    logic [31:0]      col_pos;
    logic [31:0]      row_pos;
    logic [31:0]      emit_count;
    logic [CFGW-1:0]  cfg_width;
    logic [CFGW-1:0]  cfg_height;

    // Pending pixels to send and filtered pixels still due
    pix_item_t pix_feed [$];
    mean_out_t mean_due [$];

    logic        in_took;
    logic [31:0] stuck_cycles;
    int          fail_cnt;
    int          burst_left;
    int          gap_left;
    logic [31:0] rx_tick;
    int          stall_left;
    logic        stall_req;

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Advance the filter model by one transaction, queue its output if any
    task automatic step_box_filter(input pix_item_t it);
        logic [31:0] w, h, col, p, r, c;
        logic [63:0] t;
        logic [PXW-1:0] v;
        logic [12:0] sum;
        mean_out_t res;
        w = (cfg_width == 0) ? 32'd1 : ((cfg_width > MAXW) ? 32'(MAXW) : 32'(cfg_width));
        h = (cfg_height == 0) ? 32'd1 : 32'(cfg_height);
        v = it.drain ? '0 : it.pix;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        col = col_pos;
        // shift window, pull in the new column from the line stores
        for (int k = 0; k < 5; k++)
            for (int j = 0; j < 4; j++)
                win[k][j] = win[k][j+1];
        for (int k = 0; k < 4; k++)
            win[k][4] = line_mem[k][col];
        win[4][4] = v;
        for (int k = 0; k < 3; k++)
            line_mem[k][col] = line_mem[k+1][col];
        line_mem[3][col] = v;
        t = 64'(row_pos) * 64'(w) + 64'(col_pos);
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        // nothing comes out until the window has filled
        if (t >= 64'(2 * w + 2))
        begin
            p = emit_count;
            r = p / w;
            c = p % w;
            if (r >= 2 && r + 2 < h && c >= 2 && c + 2 < w)
            begin
                sum = '0;
                for (int k = 0; k < 5; k++)
                    for (int j = 0; j < 5; j++)
                        sum += 13'(win[k][j]);
                res.pix = PXW'(sum / WIN_AREA);
            end
            else
                res.pix = win[2][2];
            res.last = (64'(p) + 1 >= 64'(w) * 64'(h));
            if (res.last)
            begin
                col_pos = 0;
                row_pos = 0;
                emit_count = 0;
            end
            else
                emit_count++;
            mean_due.push_back(res);
        end
    endtask

    // Input driver: bursts from the pending queue with gaps between them
    always @(negedge clk)
    begin
        pix_item_t cur;
        if (rst_n && (!pin.valid || in_took))
        begin
            in_took = 1'b0;
            if (gap_left != 0)
            begin
                gap_left--;
                pin.valid <= 1'b0;
            end
            else if (pix_feed.size() != 0)
            begin
                cur = pix_feed.pop_front();
                pin.pixel_in <= cur.pix;
                pin.drain    <= cur.drain;
                pin.valid    <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                pin.valid <= 1'b0;
        end
    end

    // Output ready: long hold on request, else a fixed stall pattern with quiet stretches
    always @(negedge clk)
    begin
        rx_tick++;
        if (stall_req)
        begin
            stall_req = 1'b0;
            stall_left = LONG_STALL;
        end
        if (stall_left != 0)
        begin
            stall_left--;
            pout.ready <= 1'b0;
        end
        else if (rx_tick[9:8] == 2'b00)
            pout.ready <= 1'b1;
        else
            pout.ready <= (rx_tick % 7 != 3) && (rx_tick % 13 > 2);
    end

    // Monitor: predict on input transactions, check output transactions, watchdog
    always @(posedge clk)
    begin
        mean_out_t exp_out;
        logic in_acc, out_acc;
        if (rst_n)
        begin
            in_acc  = pin.valid && pin.ready;
            out_acc = pout.valid && pout.ready;
            if (in_acc)
            begin
                step_box_filter('{pix: pin.pixel_in, drain: pin.drain});
                in_took = 1'b1;
            end
            if (out_acc)
            begin
                if (mean_due.size() == 0)
                begin
                    $error("pixel_out: no result expected, got %0d (frame_last %0d)",
                           pout.pixel_out, pout.frame_last);
                    fail_cnt++;
                end
                else
                begin
                    exp_out = mean_due.pop_front();
                    if (pout.pixel_out !== exp_out.pix)
                    begin
                        $error("pixel_out: expected %0d, got %0d", exp_out.pix, pout.pixel_out);
                        fail_cnt++;
                    end
                    if (pout.frame_last !== exp_out.last)
                    begin
                        $error("frame_last: expected %0d, got %0d", exp_out.last,
                               pout.frame_last);
                        fail_cnt++;
                    end
                end
            end
            if (in_acc || out_acc)
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic push_pixel(input logic [PXW-1:0] pix, input logic drain);
        pix_feed.push_back('{pix: pix, drain: drain});
    endtask

    // Register write; the model follows at once since the block is idle
    task automatic write_reg(input logic [IDXW-1:0] idx, input logic [CFGW-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == bxf_pkg::CFG_IMAGE_WIDTH)
            cfg_width = val;
        else
            cfg_height = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_sent();
        while (pix_feed.size() != 0 || pin.valid)
            @(posedge clk);
    endtask

    // Waits until every pending pixel is sent and every expected result is out, then lets the outputs settle
    task automatic wait_drained();
        wait_sent();
        while (mean_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Queue one frame plus its flush drains, or only the first 'cut' items
    task automatic queue_frame(input int w, input int h, input fill_t mode, input int cut,
                               output int n);
        int total;
        logic [PXW-1:0] pix;
        logic drain;
        total = (cut > 0) ? cut : w * h + 2 * w + 2;
        for (int i = 0; i < total; i++)
        begin
            pix = PXW'($urandom);
            drain = 1'b0;
            if (i >= w * h)
                drain = 1'b1;
            else
                case (mode)
                    FILL_WHITE:   pix = '1;
                    FILL_BLACK:   pix = '0;
                    FILL_SPECKLE: drain = ($urandom_range(0, 9) == 0);
                    default:
                        if ($urandom_range(0, 7) == 0)
                            pix = $urandom_range(0, 1) ? '1 : '0;
                endcase
            push_pixel(pix, drain);
        end
        n = total;
    endtask

    // Drain one item at a time until the model sits at the start of a frame
    task automatic realign_frame();
        while (col_pos != 0 || row_pos != 0 || emit_count != 0)
        begin
            push_pixel(PXW'($urandom), 1'b1);
            wait_sent();
        end
    endtask

    // Stimulus
    initial
    begin
        int n, fw, fh, nfr, cut, grp, rand_items, ew, eh;
        bit stall_done;
        int ext_w [4];
        int ext_h [4];
        ext_w = '{2048, 4095, 0, 1};
        ext_h = '{0, 1, 4095, 1};
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = bxf_pkg::CFG_IMAGE_WIDTH;
        cfg_data     = '0;
        pin.valid    = 1'b0;
        pin.pixel_in = '0;
        pin.drain    = 1'b0;
        pout.ready   = 1'b0;
        in_took      = 1'b0;
        stuck_cycles = 0;
        fail_cnt     = 0;
        burst_left   = 1;
        gap_left     = 0;
        rx_tick      = 0;
        stall_left   = 0;
        stall_req    = 1'b0;
        stall_done   = 1'b0;
        cfg_width    = CFGW'(bxf_pkg::RESET_WIDTH);
        cfg_height   = CFGW'(bxf_pkg::RESET_HEIGHT);
        col_pos      = 0;
        row_pos      = 0;
        emit_count   = 0;
        for (int k = 0; k < 4; k++)
            for (int c = 0; c < MAXW; c++)
                line_mem[k][c] = '0;
        for (int k = 0; k < 5; k++)
            for (int j = 0; j < 5; j++)
                win[k][j] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: smallest frame with one interior pixel, black corner,
        // white elsewhere, a drain inside the window
        write_reg(bxf_pkg::CFG_IMAGE_WIDTH, 12'd5);
        write_reg(bxf_pkg::CFG_IMAGE_HEIGHT, 12'd5);
        for (int i = 0; i < 25; i++)
            push_pixel((i == 0) ? 8'd0 : 8'd255, i == 12);
        for (int i = 0; i < 12; i++)
            push_pixel(PXW'($urandom), 1'b1);
        wait_drained();

        // Directed: size change mid-frame, shrinking below the outputs already given
        write_reg(bxf_pkg::CFG_IMAGE_WIDTH, 12'd6);
        write_reg(bxf_pkg::CFG_IMAGE_HEIGHT, 12'd6);
        queue_frame(6, 6, FILL_NOISE, 20, n);
        wait_drained();
        write_reg(bxf_pkg::CFG_IMAGE_WIDTH, 12'd5);
        write_reg(bxf_pkg::CFG_IMAGE_HEIGHT, 12'd1);
        realign_frame();

        // Random frames at small sizes, some cut short by a size change
        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            fw = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 14);
            fh = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 10);
            wait_drained();
            write_reg(bxf_pkg::CFG_IMAGE_WIDTH, CFGW'(fw));
            write_reg(bxf_pkg::CFG_IMAGE_HEIGHT, CFGW'(fh));
            nfr = $urandom_range(1, 3);
            grp = 0;
            cut = 0;
            for (int f = 0; f < nfr; f++)
            begin
                if (f == nfr - 1 && $urandom_range(0, 6) == 0)
                    cut = $urandom_range(1, fw * fh + 2 * fw + 1);
                queue_frame(fw, fh, fill_t'($urandom_range(0, 3)), cut, n);
                grp += n;
            end
            rand_items += grp;
            // hold the output long enough that the input backs up
            if (!stall_done && grp >= 60)
            begin
                stall_req = 1'b1;
                stall_done = 1'b1;
            end
            if (cut != 0)
            begin
                wait_drained();
                write_reg(bxf_pkg::CFG_IMAGE_WIDTH, CFGW'($urandom_range(1, 14)));
                write_reg(bxf_pkg::CFG_IMAGE_HEIGHT, CFGW'($urandom_range(1, 10)));
                realign_frame();
            end
        end

        // Register extremes, including values outside the legal range; large
        // frames are cut short and closed by a switch to a small size
        for (int e = 0; e < 4; e++)
        begin
            wait_drained();
            write_reg(bxf_pkg::CFG_IMAGE_WIDTH, CFGW'(ext_w[e]));
            write_reg(bxf_pkg::CFG_IMAGE_HEIGHT, CFGW'(ext_h[e]));
            ew = (ext_w[e] == 0) ? 1 : ((ext_w[e] > MAXW) ? MAXW : ext_w[e]);
            eh = (ext_h[e] == 0) ? 1 : ext_h[e];
            cut = (ew * eh + 2 * ew + 2 > EXT_ITEMS) ? EXT_ITEMS : 0;
            queue_frame(ew, eh, FILL_NOISE, cut, n);
            if (cut != 0)
            begin
                wait_drained();
                write_reg(bxf_pkg::CFG_IMAGE_WIDTH, 12'd5);
                write_reg(bxf_pkg::CFG_IMAGE_HEIGHT, 12'd1);
                realign_frame();
            end
        end

        // Wind down
        wait_sent();
        while (mean_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
